FILE: rtl/sprite_blit_color_key_blend_core_defines.svh
// Assertion macros for the sprite blitter core.
`ifndef SPRITE_BLIT_COLOR_KEY_BLEND_CORE_DEFINES_SVH
`define SPRITE_BLIT_COLOR_KEY_BLEND_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on the core clock.
`define SBCB_ASSERT_IMPLY(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error("sprite blitter check failed");
// Next-cycle implication, sampled on the core clock.
`define SBCB_ASSERT_NEXT(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("sprite blitter check failed");
`else
`define SBCB_ASSERT_IMPLY(label, trig, cons)
`define SBCB_ASSERT_NEXT(label, trig, cons)
`endif
`endif

FILE: rtl/sbcb_pkg.sv
package sbcb_pkg;

   // Default screen size.
   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;

   // Fixed field widths.
   localparam int PIXEL_W     = 16;
   localparam int COUNT_W     = 10;
   localparam int READ_COL_W  = 9;
   localparam int READ_ROW_W  = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_X         = 3'd0,
      CSR_ORIGIN_Y         = 3'd1,
      CSR_RECT_WIDTH       = 3'd2,
      CSR_RECT_HEIGHT      = 3'd3,
      CSR_HALF_TRANSPARENT = 3'd4
   } csr_index_type;

   // One request as it leaves the address stage.
   typedef struct packed {
      logic               is_read;
      logic               hit;
      logic               last;
      logic               blend;
      logic [PIXEL_W-1:0] src;
   } item_type;

   // Per-channel mix of stored and source pixel: (old*128 + new*127) >> 8.
   function automatic logic [PIXEL_W-1:0] mix_half(input logic [PIXEL_W-1:0] old_px,
                                                   input logic [PIXEL_W-1:0] src_px);
      logic [12:0] r_sum;
      logic [13:0] g_sum;
      logic [12:0] b_sum;
      r_sum = 13'({old_px[15:11], 7'd0}) + 13'({src_px[15:11], 7'd0})
              - 13'(src_px[15:11]);
      g_sum = 14'({old_px[10:5], 7'd0}) + 14'({src_px[10:5], 7'd0})
              - 14'(src_px[10:5]);
      b_sum = 13'({old_px[4:0], 7'd0}) + 13'({src_px[4:0], 7'd0})
              - 13'(src_px[4:0]);
      return {r_sum[12:8], g_sum[13:8], b_sum[12:8]};
   endfunction

endpackage

FILE: rtl/sbcb_locate.sv
module sbcb_locate #(
   parameter int SCREEN_WIDTH  = sbcb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = sbcb_pkg::SCREEN_HEIGHT_DEF,
   localparam int ADDR_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [sbcb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sbcb_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                               accept,
   input  logic                               req_op,
   input  logic [sbcb_pkg::PIXEL_W-1:0]       req_source_pixel,
   input  logic [sbcb_pkg::READ_COL_W-1:0]    req_read_col,
   input  logic [sbcb_pkg::READ_ROW_W-1:0]    req_read_row,
   output sbcb_pkg::item_type                 item,
   output logic [ADDR_W-1:0]                  addr
);

   localparam int COL_W = $clog2(SCREEN_WIDTH);
   localparam int ROW_W = $clog2(SCREEN_HEIGHT);

   logic [15:0]                   origin_x_ff, origin_x_in;
   logic [15:0]                   origin_y_ff, origin_y_in;
   logic [sbcb_pkg::COUNT_W-1:0]  rect_width_ff, rect_width_in;
   logic [sbcb_pkg::COUNT_W-1:0]  rect_height_ff, rect_height_in;
   logic                          half_ff, half_in;
   logic                          csr_known;
   logic [sbcb_pkg::COUNT_W-1:0]  col_ff, col_in;
   logic [sbcb_pkg::COUNT_W-1:0]  row_ff, row_in;
   logic [16:0]                   vx_sum, vy_sum;
   logic                          vx_on, vy_on, read_on, empty, col_end, row_end;
   logic [COL_W-1:0]              col_sel;
   logic [ROW_W-1:0]              row_sel;

   // Register writes; an index beyond the list changes nothing.
   always_comb begin
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      rect_width_in  = rect_width_ff;
      rect_height_in = rect_height_ff;
      half_in        = half_ff;
      csr_known      = 1'b0;
      if (csr_write_enable) begin
         unique case (sbcb_pkg::csr_index_type'(csr_index))
            sbcb_pkg::CSR_ORIGIN_X: begin
               origin_x_in = csr_write_data;
               csr_known   = 1'b1;
            end
            sbcb_pkg::CSR_ORIGIN_Y: begin
               origin_y_in = csr_write_data;
               csr_known   = 1'b1;
            end
            sbcb_pkg::CSR_RECT_WIDTH: begin
               rect_width_in = csr_write_data[sbcb_pkg::COUNT_W-1:0];
               csr_known     = 1'b1;
            end
            sbcb_pkg::CSR_RECT_HEIGHT: begin
               rect_height_in = csr_write_data[sbcb_pkg::COUNT_W-1:0];
               csr_known      = 1'b1;
            end
            sbcb_pkg::CSR_HALF_TRANSPARENT: begin
               half_in   = csr_write_data[0];
               csr_known = 1'b1;
            end
            default: csr_known = 1'b0;
         endcase
      end
   end

   // Screen position of the next source pixel and clipping.
   always_comb begin
      vx_sum  = {origin_x_ff[15], origin_x_ff} + {7'd0, col_ff};
      vy_sum  = {origin_y_ff[15], origin_y_ff} + {7'd0, row_ff};
      vx_on   = !vx_sum[16] && (vx_sum[15:0] < 16'(SCREEN_WIDTH));
      vy_on   = !vy_sum[16] && (vy_sum[15:0] < 16'(SCREEN_HEIGHT));
      read_on = (16'(req_read_col) < 16'(SCREEN_WIDTH)) &&
                (16'(req_read_row) < 16'(SCREEN_HEIGHT));
      empty   = (rect_width_ff == '0) || (rect_height_ff == '0);
      col_end = (11'(col_ff) + 11'd1) >= 11'(rect_width_ff);
      row_end = (11'(row_ff) + 11'd1) >= 11'(rect_height_ff);
   end

   // Frame address of the request.
   always_comb begin
      if (req_op) begin
         col_sel = COL_W'(req_read_col);
         row_sel = ROW_W'(req_read_row);
      end else begin
         col_sel = vx_sum[COL_W-1:0];
         row_sel = vy_sum[ROW_W-1:0];
      end
      addr = ADDR_W'(row_sel * SCREEN_WIDTH) + ADDR_W'(col_sel);
   end

   // Request summary for the blend stage.
   always_comb begin
      item.is_read = req_op;
      item.hit     = req_op ? read_on
                            : (!empty && vx_on && vy_on && (req_source_pixel != '0));
      item.last    = !req_op && (empty || (col_end && row_end));
      item.blend   = half_ff;
      item.src     = req_source_pixel;
   end

   // Rectangle walk counters.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_known) begin
         col_in = '0;
         row_in = '0;
      end else if (accept && !req_op) begin
         if (empty) begin
            col_in = '0;
            row_in = '0;
         end else if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         rect_width_ff  <= '0;
         rect_height_ff <= '0;
         half_ff        <= 1'b0;
         col_ff         <= '0;
         row_ff         <= '0;
      end else begin
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         rect_width_ff  <= rect_width_in;
         rect_height_ff <= rect_height_in;
         half_ff        <= half_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
      end
   end

endmodule

FILE: rtl/sbcb_frame_mem.sv
module sbcb_frame_mem #(
   parameter int SCREEN_WIDTH  = sbcb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = sbcb_pkg::SCREEN_HEIGHT_DEF,
   localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [sbcb_pkg::PIXEL_W-1:0]   rd_data,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [sbcb_pkg::PIXEL_W-1:0]   wr_data,
   output logic                           clearing
);

   logic [sbcb_pkg::PIXEL_W-1:0] frame_store [0:DEPTH-1];
   logic [sbcb_pkg::PIXEL_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]            clr_addr_ff, clr_addr_in;
   logic                         clearing_ff, clearing_in;
   logic                         mem_we;
   logic [ADDR_W-1:0]            mem_waddr;
   logic [sbcb_pkg::PIXEL_W-1:0] mem_wdata;

   // Clearing pass after reset: one entry per cycle.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clearing_ff <= clearing_in;
      end
   end

   // Write port is shared by the clearing pass and the blend stage.
   always_comb begin
      mem_we    = clearing_ff || wr_en;
      mem_waddr = clearing_ff ? clr_addr_ff : wr_addr;
      mem_wdata = clearing_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store[mem_waddr] <= mem_wdata;
      end
   end

   // Registered read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_store[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

FILE: rtl/sbcb_merge.sv
module sbcb_merge #(
   parameter int ADDR_W = 17
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  sbcb_pkg::item_type             item,
   input  logic [ADDR_W-1:0]              addr,
   input  logic [sbcb_pkg::PIXEL_W-1:0]   rd_data,
   output logic                           s1_valid,
   output logic                           hold,
   output logic                           wr_en,
   output logic [ADDR_W-1:0]              wr_addr,
   output logic [sbcb_pkg::PIXEL_W-1:0]   wr_data,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [sbcb_pkg::PIXEL_W-1:0]   rsp_pixel_value,
   output logic                           rsp_written,
   output logic                           rsp_last
);

   logic                          s1_valid_ff, s1_valid_in;
   sbcb_pkg::item_type            s1_item_ff;
   logic [ADDR_W-1:0]             s1_addr_ff;
   logic                          fwd_ff, fwd_in;
   logic [sbcb_pkg::PIXEL_W-1:0]  fwd_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sbcb_pkg::PIXEL_W-1:0]  rsp_pixel_ff;
   logic                          rsp_written_ff, rsp_last_ff;
   logic                          s1_adv;
   logic [sbcb_pkg::PIXEL_W-1:0]  old_px, value;

   // The stage moves on when the output register is free or being drained.
   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign hold   = s1_valid_ff && !s1_adv;

   // Stored pixel, with the write made in the cycle of this read forwarded.
   always_comb begin
      old_px = fwd_ff ? fwd_data_ff : rd_data;
      if (!s1_item_ff.hit) begin
         value = '0;
      end else if (s1_item_ff.is_read) begin
         value = old_px;
      end else if (s1_item_ff.blend) begin
         value = sbcb_pkg::mix_half(old_px, s1_item_ff.src);
      end else begin
         value = s1_item_ff.src;
      end
      wr_en   = s1_adv && s1_item_ff.hit && !s1_item_ff.is_read;
      wr_addr = s1_addr_ff;
      wr_data = value;
      fwd_in  = wr_en && (addr == s1_addr_ff);
   end

   // Stage and output valid flags.
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff  <= item;
         s1_addr_ff  <= addr;
         fwd_data_ff <= value;
      end
      if (s1_adv) begin
         rsp_pixel_ff   <= value;
         rsp_written_ff <= wr_en;
         rsp_last_ff    <= s1_item_ff.last;
      end
   end

   assign s1_valid        = s1_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_written     = rsp_written_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: rtl/sprite_blit_color_key_blend_core.sv
// Channel   Direction  Handshake        Payload
// req       in         valid / stall    op, source_pixel, read_col, read_row
// rsp       out        valid / stall    pixel_value, written, last
// csr       in         write_enable     index, write_data
//
// One request per cycle while req_stall is low; a result passes the blend stage
// register, then the output register. Each blit reads the frame memory on accept,
// writes it as the stage moves on, and forwards that write to a same-pixel read.
// After reset the frame memory is cleared one pixel per cycle, SCREEN_WIDTH *
// SCREEN_HEIGHT pixels (76800 at 320 x 240); req_stall is high while it runs.
// rsp_stall holds the blend stage, which then raises req_stall.
`include "sprite_blit_color_key_blend_core_defines.svh"

module sprite_blit_color_key_blend_core #(
   parameter int SCREEN_WIDTH  = sbcb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = sbcb_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [sbcb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sbcb_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [sbcb_pkg::PIXEL_W-1:0]       req_source_pixel,
   input  logic [sbcb_pkg::READ_COL_W-1:0]    req_read_col,
   input  logic [sbcb_pkg::READ_ROW_W-1:0]    req_read_row,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sbcb_pkg::PIXEL_W-1:0]       rsp_pixel_value,
   output logic                               rsp_written,
   output logic                               rsp_last
);

   localparam int ADDR_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);

   logic                          accept;
   logic                          clearing;
   logic                          hold;
   logic                          s1_valid;
   sbcb_pkg::item_type            item;
   logic [ADDR_W-1:0]             addr;
   logic [sbcb_pkg::PIXEL_W-1:0]  rd_data;
   logic                          blit_wr_en;
   logic [ADDR_W-1:0]             blit_wr_addr;
   logic [sbcb_pkg::PIXEL_W-1:0]  blit_wr_data;

   // A request enters when the memory is ready and the blend stage can move.
   assign req_stall = clearing || hold;
   assign accept    = req_valid && !req_stall;

   sbcb_locate #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_locate (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_op           (req_op),
      .req_source_pixel (req_source_pixel),
      .req_read_col     (req_read_col),
      .req_read_row     (req_read_row),
      .item             (item),
      .addr             (addr)
   );

   sbcb_frame_mem #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_frame_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (addr),
      .rd_data  (rd_data),
      .wr_en    (blit_wr_en),
      .wr_addr  (blit_wr_addr),
      .wr_data  (blit_wr_data),
      .clearing (clearing)
   );

   sbcb_merge #(
      .ADDR_W (ADDR_W)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .item            (item),
      .addr            (addr),
      .rd_data         (rd_data),
      .s1_valid        (s1_valid),
      .hold            (hold),
      .wr_en           (blit_wr_en),
      .wr_addr         (blit_wr_addr),
      .wr_data         (blit_wr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_written     (rsp_written),
      .rsp_last        (rsp_last)
   );

   // The clearing pass owns the write port alone.
   `SBCB_ASSERT_IMPLY(a_no_blit_while_clearing, clearing, !blit_wr_en)
   // An accepted request is in the blend stage in the next cycle.
   `SBCB_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid)
   // A blend stage that moves on leaves a result in the output register.
   `SBCB_ASSERT_NEXT(a_stage_yields_result, s1_valid && !hold, rsp_valid)

endmodule

FILE: test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIXEL_W     = sbcb_pkg::PIXEL_W;
   localparam int COUNT_W     = sbcb_pkg::COUNT_W;
   localparam int READ_COL_W  = sbcb_pkg::READ_COL_W;
   localparam int READ_ROW_W  = sbcb_pkg::READ_ROW_W;
   localparam int CSR_INDEX_W = sbcb_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = sbcb_pkg::CSR_DATA_W;

   localparam int CLOCK_PERIOD    = 10;
   localparam int SCREEN_W        = sbcb_pkg::SCREEN_WIDTH_DEF;
   localparam int SCREEN_H        = sbcb_pkg::SCREEN_HEIGHT_DEF;
   localparam logic OP_BLIT       = 1'b0;
   localparam logic OP_READ       = 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LAST  = 3'd7;
   // Extra idle wait after the last expected result, as a margin.
   localparam int PIPE_SETTLE     = 6;
   // The limit outlasts the clearing pass after reset, which keeps the input stalled.
   localparam int WATCHDOG_LIMIT  = 250000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_REQUESTS = 1700;
   localparam int MAX_PRINTED     = 40;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic               written;
      logic               last;
   } pixel_result_type;

   // Block ports.
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_op           = 1'b0;
   logic [PIXEL_W-1:0]     req_source_pixel = '0;
   logic [READ_COL_W-1:0]  req_read_col     = '0;
   logic [READ_ROW_W-1:0]  req_read_row     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [PIXEL_W-1:0]     rsp_pixel_value;
   logic                   rsp_written;
   logic                   rsp_last;

   // Predicted framebuffer, draw position and rectangle settings.
   logic [PIXEL_W-1:0] frame_model [SCREEN_W*SCREEN_H];
   int unsigned        next_col  = 0;
   int unsigned        next_row  = 0;
   int                 view_x0   = 0;
   int                 view_y0   = 0;
   int unsigned        rect_w    = 0;
   int unsigned        rect_h    = 0;
   bit                 blend_on  = 1'b0;
   pixel_result_type   expected_pixels [$];

   // Idling controls shared between the tests and the receiver process.
   bit gaps_on      = 1'b1;
   bit rsp_gaps_on  = 1'b1;
   bit hold_request = 1'b0;
   int hold_left    = 0;
   int quiet_cycles = 0;

   // Tallies for the closing summary.
   int blits_sent      = 0;
   int reads_sent      = 0;
   int pixels_stored   = 0;
   int pixels_blended  = 0;
   int pixels_dropped  = 0;
   int rects_done      = 0;
   int csr_writes      = 0;
   int results_checked = 0;
   int error_count     = 0;

   sprite_blit_color_key_blend_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_source_pixel (req_source_pixel),
      .req_read_col     (req_read_col),
      .req_read_row     (req_read_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_written      (rsp_written),
      .rsp_last         (rsp_last)
   );

   always #(CLOCK_PERIOD/2) clock = ~clock;

   // Per-channel half blend: (stored*128 + incoming*127) >> 8.
   function automatic logic [PIXEL_W-1:0] blend_half(input logic [PIXEL_W-1:0] stored,
                                                     input logic [PIXEL_W-1:0] incoming);
      int unsigned red, green, blue;
      red   = (32'(stored[15:11]) * 128 + 32'(incoming[15:11]) * 127) >> 8;
      green = (32'(stored[10:5]) * 128 + 32'(incoming[10:5]) * 127) >> 8;
      blue  = (32'(stored[4:0]) * 128 + 32'(incoming[4:0]) * 127) >> 8;
      return {red[4:0], green[5:0], blue[4:0]};
   endfunction

   // Works out the result of one accepted request and updates the predicted state.
   function automatic void predict_pixel(input logic op, input logic [PIXEL_W-1:0] pixel,
                                         input logic [READ_COL_W-1:0] col,
                                         input logic [READ_ROW_W-1:0] row);
      pixel_result_type outcome;
      int               px, py, addr;
      outcome = '0;
      if (op == OP_READ) begin
         reads_sent++;
         if (int'(col) < SCREEN_W && int'(row) < SCREEN_H)
            outcome.pixel_value = frame_model[int'(row) * SCREEN_W + int'(col)];
      end else if (rect_w == 0 || rect_h == 0) begin
         // An empty rectangle ends at once and never moves the counters.
         blits_sent++;
         outcome.last = 1'b1;
         next_col = 0;
         next_row = 0;
      end else begin
         blits_sent++;
         px = view_x0 + int'(next_col);
         py = view_y0 + int'(next_row);
         if (px >= 0 && py >= 0 && px < SCREEN_W && py < SCREEN_H && pixel != '0) begin
            addr = py * SCREEN_W + px;
            outcome.pixel_value = blend_on ? blend_half(frame_model[addr], pixel) : pixel;
            frame_model[addr] = outcome.pixel_value;
            outcome.written = 1'b1;
            pixels_stored++;
            if (blend_on)
               pixels_blended++;
         end else begin
            pixels_dropped++;
         end
         // Row-major walk over the rectangle.
         if (next_col + 1 >= rect_w) begin
            next_col = 0;
            if (next_row + 1 >= rect_h) begin
               next_row = 0;
               outcome.last = 1'b1;
            end else begin
               next_row++;
            end
         end else begin
            next_col++;
         end
      end
      if (outcome.last)
         rects_done++;
      expected_pixels.push_back(outcome);
   endfunction

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      if (error_count < MAX_PRINTED)
         $display("mismatch at %0t ns: %s expected %0h, got %0h", $time, field, want, got);
      error_count++;
   endtask

   // Offers one request, optionally after a random gap, and waits for it to be taken.
   task automatic send_request(input logic op, input logic [PIXEL_W-1:0] pixel,
                               input logic [READ_COL_W-1:0] col,
                               input logic [READ_ROW_W-1:0] row);
      int gap;
      if (gaps_on && $urandom_range(0, 99) < 8) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_source_pixel <= pixel;
      req_read_col     <= col;
      req_read_row     <= row;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_pixel(op, pixel, col, row);
   endtask

   // Lowers valid and waits until every expected result has come out.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // One register write; the caller lowers the enable after the last write.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_writes++;
      case (index)
         sbcb_pkg::CSR_ORIGIN_X:         view_x0 = int'($signed(data));
         sbcb_pkg::CSR_ORIGIN_Y:         view_y0 = int'($signed(data));
         sbcb_pkg::CSR_RECT_WIDTH:       rect_w = 32'(data[COUNT_W-1:0]);
         sbcb_pkg::CSR_RECT_HEIGHT:      rect_h = 32'(data[COUNT_W-1:0]);
         sbcb_pkg::CSR_HALF_TRANSPARENT: blend_on = data[0];
         default:                        return;
      endcase
      next_col = 0;
      next_row = 0;
   endtask

   task automatic poke_csr(input logic [CSR_INDEX_W-1:0] index,
                           input logic [CSR_DATA_W-1:0] data);
      write_csr(index, data);
      csr_write_enable <= 1'b0;
   endtask

   // Writes all five registers; values wider than a register lose their upper bits.
   task automatic set_rect(input int x0, input int y0, input int width_word,
                           input int height_word, input int blend_word);
      write_csr(sbcb_pkg::CSR_ORIGIN_X, CSR_DATA_W'(x0));
      write_csr(sbcb_pkg::CSR_ORIGIN_Y, CSR_DATA_W'(y0));
      write_csr(sbcb_pkg::CSR_RECT_WIDTH, CSR_DATA_W'(width_word));
      write_csr(sbcb_pkg::CSR_RECT_HEIGHT, CSR_DATA_W'(height_word));
      write_csr(sbcb_pkg::CSR_HALF_TRANSPARENT, CSR_DATA_W'(blend_word));
      csr_write_enable <= 1'b0;
   endtask

   // Reads after the clearing pass must all come back zero.
   task automatic test_cleared_reads();
      send_request(OP_READ, 16'h0000, 0, 0);
      send_request(OP_READ, 16'hFFFF, READ_COL_W'(SCREEN_W - 1), READ_ROW_W'(SCREEN_H - 1));
      send_request(OP_READ, 16'h0000, READ_COL_W'(SCREEN_W), READ_ROW_W'(SCREEN_H));
   endtask

   // Zero width or zero height: each blit ends the rectangle and stores nothing.
   task automatic test_empty_rectangle();
      send_request(OP_BLIT, 16'hFFFF, 0, 0);
      wait_idle();
      set_rect(5, 5, 3, 0, 0);
      send_request(OP_BLIT, 16'h1234, 0, 0);
   endtask

   // A 3x3 rectangle over the bottom-right corner: clipped right, clipped below,
   // and a transparent pixel in between.
   task automatic test_corner_clipping();
      wait_idle();
      set_rect(SCREEN_W - 2, SCREEN_H - 2, 3, 3, 0);
      send_request(OP_BLIT, 16'hFFFF, 0, 0);
      send_request(OP_BLIT, 16'h0000, 0, 0);
      send_request(OP_BLIT, 16'h8000, 0, 0);
      send_request(OP_BLIT, 16'h8421, 0, 0);
      send_request(OP_BLIT, 16'h0001, 0, 0);
      send_request(OP_BLIT, 16'h7BEF, 0, 0);
      send_request(OP_BLIT, 16'h7BEF, 0, 0);
      send_request(OP_BLIT, 16'hF800, 0, 0);
      send_request(OP_BLIT, 16'h07E0, 0, 0);
      send_request(OP_READ, 16'h0000, READ_COL_W'(SCREEN_W - 1), READ_ROW_W'(SCREEN_H - 1));
      send_request(OP_READ, 16'h0000, READ_COL_W'(SCREEN_W - 2), READ_ROW_W'(SCREEN_H - 2));
   endtask

   // Negative origins clip left and above; the extreme origins clip everything.
   task automatic test_negative_origins();
      wait_idle();
      set_rect(-1, -1, 2, 2, 0);
      repeat (4) send_request(OP_BLIT, 16'h1234, 0, 0);
      wait_idle();
      set_rect(-32768, 32767, 1023, 1023, 0);
      repeat (2) send_request(OP_BLIT, 16'hABCD, 0, 0);
      wait_idle();
      set_rect(32767, -32768, 1, 1, 0);
      send_request(OP_BLIT, 16'hABCD, 0, 0);
   endtask

   // Blend full white onto full white, and a faint pixel onto black that blends to zero.
   task automatic test_half_blend();
      wait_idle();
      set_rect(SCREEN_W - 2, SCREEN_H - 2, 2, 1, 1);
      send_request(OP_BLIT, 16'hFFFF, 0, 0);
      send_request(OP_BLIT, 16'h0001, 0, 0);
   endtask

   // Writes to unused indexes keep the draw position; a real write restarts it.
   task automatic test_counter_restart();
      wait_idle();
      set_rect(10, 20, 4, 2, 0);
      send_request(OP_BLIT, 16'h0F0F, 0, 0);
      send_request(OP_BLIT, 16'hF0F0, 0, 0);
      wait_idle();
      poke_csr(CSR_UNUSED_FIRST, 16'hFFFF);
      send_request(OP_BLIT, 16'h3333, 0, 0);
      wait_idle();
      poke_csr(CSR_UNUSED_LAST, 16'h0000);
      send_request(OP_BLIT, 16'h5555, 0, 0);
      wait_idle();
      poke_csr(sbcb_pkg::CSR_HALF_TRANSPARENT, 16'h0000);
      send_request(OP_BLIT, 16'hAAAA, 0, 0);
      send_request(OP_READ, 16'h0000, 13, 20);
   endtask

   // The receiver holds off while requests keep coming, so the block backs up.
   task automatic test_output_backpressure();
      int k;
      wait_idle();
      set_rect(100, 100, 8, 8, 1);
      gaps_on = 1'b0;
      hold_request = 1'b1;
      for (k = 0; k < 64; k++)
         send_request(OP_BLIT, PIXEL_W'($urandom | 1), 0, 0);
      gaps_on = 1'b1;
   endtask

   // Random rectangles drawn mostly to completion, with reads mixed in.
   task automatic test_random_sprites();
      int                 sent, shape, width_word, height_word, x0, y0;
      int                 total, k, span_w, span_h, roll;
      logic [PIXEL_W-1:0] pixel;
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         // A long stretch in the middle runs with no idling on either side.
         gaps_on     = (sent < 600 || sent >= 1000);
         rsp_gaps_on = gaps_on;
         wait_idle();

         shape = $urandom_range(0, 19);
         if (shape == 0) begin
            width_word  = $urandom_range(0, 1) ? 0 : $urandom_range(1, 9);
            height_word = (width_word == 0) ? $urandom_range(0, 9) : 0;
         end else if (shape == 1) begin
            width_word  = $urandom_range(0, 1) ? 1023 : $urandom_range(100, 1023);
            height_word = $urandom_range(0, 1) ? 1023 : $urandom_range(1, 1023);
         end else begin
            width_word  = $urandom_range(1, 12);
            height_word = $urandom_range(1, 8);
         end
         width_word  |= $urandom_range(0, 63) << COUNT_W;
         height_word |= $urandom_range(0, 63) << COUNT_W;
         if ($urandom_range(0, 3) == 0) begin
            x0 = $urandom;
            y0 = $urandom;
         end else begin
            x0 = int'($urandom_range(0, SCREEN_W + 20)) - 16;
            y0 = int'($urandom_range(0, SCREEN_H + 20)) - 16;
         end
         set_rect(x0, y0, width_word, height_word,
                  $urandom_range(0, 1) | ($urandom_range(0, 32767) << 1));

         // How many blits this phase: full rectangles, partial ones, or a few empty blits.
         total = rect_w * rect_h;
         if (total == 0)
            total = $urandom_range(1, 3);
         else if (shape == 1)
            total = (total > 48) ? 48 : total;
         else if ($urandom_range(0, 9) == 0)
            total = $urandom_range(1, total);
         else
            total = total * $urandom_range(1, 2);
         span_w = (rect_w == 0) ? 1 : rect_w;
         span_h = (rect_h == 0) ? 1 : rect_h;

         for (k = 0; k < total; k++) begin
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 4) < 3)
                  send_request(OP_READ, PIXEL_W'($urandom),
                               READ_COL_W'(view_x0 + $urandom_range(0, span_w - 1)),
                               READ_ROW_W'(view_y0 + $urandom_range(0, span_h - 1)));
               else
                  send_request(OP_READ, PIXEL_W'($urandom),
                               READ_COL_W'($urandom_range(0, 511)),
                               READ_ROW_W'($urandom_range(0, 255)));
               sent++;
            end
            roll = $urandom_range(0, 99);
            if (roll < 12)
               pixel = '0;
            else if (roll < 20)
               pixel = '1;
            else
               pixel = PIXEL_W'($urandom);
            send_request(OP_BLIT, pixel, READ_COL_W'($urandom_range(0, 511)),
                         READ_ROW_W'($urandom_range(0, 255)));
            sent++;
         end
      end
      gaps_on     = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // Receiver: random stalls, or a counted hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_gaps_on && ($urandom_range(0, 99) < 8);
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("result with nothing outstanding", 0, 32'(rsp_pixel_value));
         end else begin
            want = expected_pixels.pop_front();
            results_checked++;
            if (rsp_pixel_value !== want.pixel_value)
               report_mismatch("pixel_value", 32'(want.pixel_value), 32'(rsp_pixel_value));
            if (rsp_written !== want.written)
               report_mismatch("written", 32'(want.written), 32'(rsp_written));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      foreach (frame_model[i])
         frame_model[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_cleared_reads();
      test_empty_rectangle();
      test_corner_clipping();
      test_negative_origins();
      test_half_blend();
      test_counter_restart();
      test_output_backpressure();
      test_random_sprites();
      wait_idle();

      $display("covered %0d blits (%0d stored, %0d blended, %0d dropped) and %0d reads",
               blits_sent, pixels_stored, pixels_blended, pixels_dropped, reads_sent);
      $display("%0d rectangles ended, %0d register writes, %0d results checked, %0d errors",
               rects_done, csr_writes, results_checked, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
